// File: hdl/mhtp_pkg.sv
// mhtp_pkg: constants, codes and shared types for the music header tag parser.
// No dependencies; used by the walker, the divider and the top level.
package mhtp_pkg;

    localparam int POS_W = 20;

    localparam logic [31:0] MAGIC_SNDH = 32'h534E4448;
    localparam logic [31:0] MAGIC_END  = 32'h48444E53;
    localparam logic [31:0] MAGIC_TIME = 32'h54494D45;
    localparam logic [31:0] MAGIC_ICE  = 32'h49434521;

    localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
    localparam logic [31:0] TAG_TITL = 32'h5449544C;
    localparam logic [31:0] TAG_RIPP = 32'h52495050;
    localparam logic [31:0] TAG_CONV = 32'h434F4E56;
    localparam logic [31:0] TAG_YEAR = 32'h59454152;
    localparam logic [31:0] TAG_NS_A = 32'h214E5323;
    localparam logic [31:0] TAG_NS_B = 32'h4E532123;
    localparam logic [31:0] TAG_NS_C = 32'h21535423;

    // first two tag bytes, little-endian
    localparam logic [15:0] W1_SONGS  = 16'h2323;
    localparam logic [15:0] W1_CUR_A  = 16'h2123;
    localparam logic [15:0] W1_CUR_B  = 16'h2321;
    localparam logic [15:0] W1_RATE_V = 16'h5621;
    localparam logic [15:0] W1_RATE_A = 16'h4154;
    localparam logic [15:0] W1_RATE_B = 16'h4254;
    localparam logic [15:0] W1_RATE_C = 16'h4354;
    localparam logic [15:0] W1_RATE_D = 16'h4454;

    localparam logic [15:0] DEFAULT_SECONDS = 16'd300;
    localparam logic [15:0] DEFAULT_RATE    = 16'd50;
    localparam logic [23:0] CPU_CLOCK_X2    = 24'd16000000;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_PACKED = 2'd2;

    localparam logic [1:0] K_SONGS = 2'd0;
    localparam logic [1:0] K_CUR   = 2'd1;
    localparam logic [1:0] K_RATE  = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic        header_found;
        logic [15:0] song_count;
        logic [15:0] sel_song;
        logic [15:0] play_rate;
        logic [15:0] song_seconds;
        logic [31:0] total_ticks;
        logic [22:0] frame_period;
    } t_result;

    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [16:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [22:0] quotient;
    } t_div_rsp;

endpackage

// File: hdl/mhtp_in_if.sv
// mhtp_in_if: byte stream channel (valid/ready) into the parser.
// No dependencies.
interface mhtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       last_byte;

    modport source (output valid, file_byte, last_byte, input ready);
    modport sink   (input valid, file_byte, last_byte, output ready);
endinterface

// File: hdl/mhtp_out_if.sv
// mhtp_out_if: result channel (valid/ready) out of the parser.
// No dependencies.
interface mhtp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        header_found;
    logic [15:0] song_count;
    logic [15:0] sel_song;
    logic [15:0] play_rate;
    logic [15:0] song_seconds;
    logic [31:0] total_ticks;
    logic [22:0] frame_period;

    modport source (output valid, status, header_found, song_count, sel_song, play_rate,
                    song_seconds, total_ticks, frame_period, input ready);
    modport sink   (input valid, status, header_found, song_count, sel_song, play_rate,
                    song_seconds, total_ticks, frame_period, output ready);
endinterface

// File: hdl/mhtp_div.sv
// mhtp_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on mhtp_pkg for request/response types.
module mhtp_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mhtp_pkg::t_div_req  i_req,
    output mhtp_pkg::t_div_rsp  o_rsp
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [16:0] r_rem;
    logic [23:0] r_q;
    logic [16:0] r_dvs;
    logic [17:0] w_sh;
    logic [17:0] w_diff;
    logic        w_ge;

    assign w_sh   = {r_rem, r_q[23]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= 17'd0;
                r_q    <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[16:0] : w_sh[16:0];
                r_q   <= {r_q[22:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done, quotient: r_q[22:0]};
endmodule

// File: hdl/mhtp_walker.sv
// mhtp_walker: header byte store, tag-list sequencer and TIME table.
// Depends on mhtp_pkg; drives the divider through t_div_req/t_div_rsp.
module mhtp_walker #(
    parameter int HEADER_BYTES = 200,
    parameter int TIMED_SONGS  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_file_byte,
    input  logic                i_last_byte,
    output logic                o_idle,
    output mhtp_pkg::t_div_req  o_div_req,
    input  mhtp_pkg::t_div_rsp  i_div_rsp,
    output logic                o_res_valid,
    output mhtp_pkg::t_result   o_res,
    input  logic                i_res_ready
);
    localparam int AW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int CW = $clog2(HEADER_BYTES + 1);
    localparam int TW = (TIMED_SONGS > 1) ? $clog2(TIMED_SONGS) : 1;
    localparam int PW = mhtp_pkg::POS_W;

    localparam logic [4:0] S_IDLE  = 5'd0,  S_FA   = 5'd1,  S_FD   = 5'd2,  S_MCHK = 5'd3;
    localparam logic [4:0] S_TAG   = 5'd4,  S_DISP = 5'd5,  S_SA   = 5'd6,  S_SD   = 5'd7;
    localparam logic [4:0] S_TA    = 5'd8,  S_THD  = 5'd9,  S_TLA  = 5'd10, S_TLD  = 5'd11;
    localparam logic [4:0] S_NA    = 5'd12, S_NHA  = 5'd13, S_NHD  = 5'd14, S_NLA  = 5'd15;
    localparam logic [4:0] S_NLD   = 5'd16, S_NJA  = 5'd17, S_NJD  = 5'd18, S_DA   = 5'd19;
    localparam logic [4:0] S_DD    = 5'd20, S_CLMP = 5'd21, S_TRD  = 5'd22, S_MUL  = 5'd23;
    localparam logic [4:0] S_DIV   = 5'd24, S_OUT  = 5'd25;

    localparam logic [2:0] C_END = 3'd0, C_TEXT = 3'd1, C_TIME = 3'd2, C_NT = 3'd3,
                           C_OTHER = 3'd4;

    logic [4:0]             r_state;
    logic [7:0]             r_mem [HEADER_BYTES];
    logic [7:0]             r_rdata;
    logic [CW-1:0]          r_cnt;
    logic [31:0]            r_first;
    logic [PW-1:0]          r_n, r_pos, r_ptr, r_tp, r_far;
    logic [15:0]            r_songs, r_cur, r_rate, r_i, r_val, r_hi;
    logic [1:0]             r_kind, r_status;
    logic                   r_found;
    logic [1:0]             r_k;
    logic [31:0]            r_dw;
    logic [15:0]            r_times [TIMED_SONGS];
    logic [TIMED_SONGS-1:0] r_tvalid;
    logic [15:0]            r_tdata;
    logic                   r_tok;
    logic [15:0]            r_secs;
    logic [31:0]            r_ticks;
    logic [22:0]            r_period;

    logic [CW-1:0] w_cnt_nx;
    logic [15:0]   w_w1;
    logic [2:0]    w_cls;
    logic          w_is_dec;
    logic [1:0]    w_kind;
    logic [PW-1:0] w_songs2;
    logic [PW-1:0] w_j;
    logic          w_digit;
    logic [19:0]   w_dv;
    logic [15:0]   w_val_nx;
    logic          w_dec_end;
    logic [15:0]   w_idx;
    logic [TW-1:0] w_tidx;
    logic          w_tin;
    logic [15:0]   w_secs;
    logic [15:0]   w_mul_a;

    assign w_cnt_nx = (r_cnt < CW'(HEADER_BYTES)) ? r_cnt + CW'(1) : r_cnt;
    assign w_w1     = {r_dw[23:16], r_dw[31:24]};
    assign w_songs2 = PW'({r_songs, 1'b0});
    assign w_j      = PW'({r_hi, r_rdata}) + r_pos - PW'(4);
    assign w_digit  = (r_rdata >= 8'h30) && (r_rdata <= 8'h39);
    assign w_dv     = ({4'd0, r_val} << 3) + ({4'd0, r_val} << 1) + 20'(r_rdata[3:0]);
    assign w_val_nx = (w_dv > 20'h0FFFF) ? 16'hFFFF : w_dv[15:0];
    assign w_dec_end = ((r_state == S_DA) && !(r_ptr < r_n))
                    || ((r_state == S_DD) && (r_rdata == 8'd0));
    assign w_idx    = r_cur - 16'd1;
    assign w_tidx   = w_idx[TW-1:0];
    assign w_tin    = w_idx < 16'(TIMED_SONGS);
    assign w_secs   = r_tok ? r_tdata : 16'd0;
    assign w_mul_a  = (w_secs != 16'd0) ? w_secs : mhtp_pkg::DEFAULT_SECONDS;

    always_comb begin
        case (r_dw) inside
            mhtp_pkg::MAGIC_END:  w_cls = C_END;
            mhtp_pkg::TAG_COMM, mhtp_pkg::TAG_TITL, mhtp_pkg::TAG_RIPP,
            mhtp_pkg::TAG_CONV, mhtp_pkg::TAG_YEAR: w_cls = C_TEXT;
            mhtp_pkg::MAGIC_TIME: w_cls = C_TIME;
            mhtp_pkg::TAG_NS_A, mhtp_pkg::TAG_NS_B, mhtp_pkg::TAG_NS_C: w_cls = C_NT;
            default:              w_cls = C_OTHER;
        endcase
    end

    always_comb begin
        w_is_dec = 1'b1;
        w_kind   = mhtp_pkg::K_RATE;
        case (w_w1) inside
            mhtp_pkg::W1_SONGS: w_kind = mhtp_pkg::K_SONGS;
            mhtp_pkg::W1_CUR_A, mhtp_pkg::W1_CUR_B: w_kind = mhtp_pkg::K_CUR;
            mhtp_pkg::W1_RATE_V, mhtp_pkg::W1_RATE_A, mhtp_pkg::W1_RATE_B,
            mhtp_pkg::W1_RATE_C, mhtp_pkg::W1_RATE_D: w_kind = mhtp_pkg::K_RATE;
            default: w_is_dec = 1'b0;
        endcase
    end

    // header store: written while loading, read at r_ptr every cycle
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_accept && (r_cnt < CW'(HEADER_BYTES))) begin
            r_mem[r_cnt[AW-1:0]] <= i_file_byte;
        end
        r_rdata <= r_mem[r_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_TLD) begin
            r_times[r_i[TW-1:0]] <= {r_hi[7:0], r_rdata};
        end
        r_tdata <= r_times[w_tidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_first  <= 32'd0;
            r_tvalid <= '0;
        end else begin
            unique case (r_state) inside
                S_IDLE: begin
                    if (i_accept) begin
                        if (!i_last_byte) begin
                            if (r_cnt < CW'(4)) r_first <= {r_first[23:0], i_file_byte};
                            r_cnt <= w_cnt_nx;
                        end else begin
                            r_cnt    <= '0;
                            r_first  <= 32'd0;
                            r_n      <= PW'(w_cnt_nx);
                            r_songs  <= 16'd1;
                            r_cur    <= 16'd1;
                            r_rate   <= mhtp_pkg::DEFAULT_RATE;
                            r_found  <= 1'b0;
                            r_tvalid <= '0;
                            if (w_cnt_nx < CW'(12)) begin
                                r_status <= mhtp_pkg::ST_SHORT;
                                r_state  <= S_TRD;
                            end else if (r_first == mhtp_pkg::MAGIC_ICE) begin
                                r_status <= mhtp_pkg::ST_PACKED;
                                r_state  <= S_TRD;
                            end else if (w_cnt_nx < CW'(32)) begin
                                r_status <= mhtp_pkg::ST_OK;
                                r_state  <= S_TRD;
                            end else begin
                                r_status <= mhtp_pkg::ST_OK;
                                r_pos    <= PW'(12);
                                r_ptr    <= PW'(12);
                                r_k      <= 2'd0;
                                r_state  <= S_FA;
                            end
                        end
                    end
                end
                S_FA: r_state <= S_FD;
                S_FD: begin
                    r_dw  <= {r_dw[23:0], r_rdata};
                    r_ptr <= r_ptr + PW'(1);
                    r_k   <= r_k + 2'd1;
                    if (r_k == 2'd3) r_state <= r_found ? S_DISP : S_MCHK;
                    else             r_state <= S_FA;
                end
                S_MCHK: begin
                    if (r_dw == mhtp_pkg::MAGIC_SNDH) begin
                        r_found <= 1'b1;
                        r_pos   <= PW'(16);
                        r_state <= S_TAG;
                    end else begin
                        r_state <= S_TRD;
                    end
                end
                S_TAG: begin
                    if (r_pos + PW'(4) <= r_n) begin
                        r_ptr   <= r_pos;
                        r_k     <= 2'd0;
                        r_state <= S_FA;
                    end else begin
                        r_state <= S_CLMP;
                    end
                end
                S_DISP: begin
                    unique case (w_cls)
                        C_END: r_state <= S_CLMP;
                        C_TEXT: begin
                            r_ptr   <= r_pos + PW'(4);
                            r_state <= S_SA;
                        end
                        C_TIME: begin
                            r_pos   <= r_pos + PW'(4);
                            r_ptr   <= r_pos + PW'(4);
                            r_i     <= 16'd0;
                            r_state <= S_TA;
                        end
                        C_NT: begin
                            r_pos   <= r_pos + PW'(4);
                            r_tp    <= r_pos + PW'(4);
                            r_far   <= r_pos + PW'(3) + w_songs2;
                            r_i     <= 16'd0;
                            r_state <= S_NA;
                        end
                        default: begin
                            if (w_is_dec) begin
                                r_ptr   <= r_pos + PW'(2);
                                r_val   <= 16'd0;
                                r_kind  <= w_kind;
                                r_state <= S_DA;
                            end else begin
                                // unknown tag: resync one byte on
                                r_pos   <= r_pos + PW'(1);
                                r_state <= S_TAG;
                            end
                        end
                    endcase
                end
                S_SA: begin
                    if (r_ptr < r_n) begin
                        r_state <= S_SD;
                    end else begin
                        r_pos   <= r_ptr + PW'(1);
                        r_state <= S_TAG;
                    end
                end
                S_SD: begin
                    if (r_rdata == 8'd0) begin
                        r_pos   <= r_ptr + PW'(1);
                        r_state <= S_TAG;
                    end else begin
                        r_ptr   <= r_ptr + PW'(1);
                        r_state <= S_SA;
                    end
                end
                S_TA: begin
                    if ((r_i < r_songs) && (r_i < 16'(TIMED_SONGS))
                            && (r_ptr + PW'(2) <= r_n)) begin
                        r_state <= S_THD;
                    end else begin
                        r_pos   <= r_pos + w_songs2;
                        r_state <= S_TAG;
                    end
                end
                S_THD: begin
                    r_hi    <= {8'd0, r_rdata};
                    r_ptr   <= r_ptr + PW'(1);
                    r_state <= S_TLA;
                end
                S_TLA: r_state <= S_TLD;
                S_TLD: begin
                    r_tvalid[r_i[TW-1:0]] <= 1'b1;
                    r_ptr   <= r_ptr + PW'(1);
                    r_i     <= r_i + 16'd1;
                    r_state <= S_TA;
                end
                S_NA: begin
                    if ((r_i < r_songs) && (r_tp + PW'(2) <= r_n)) begin
                        r_ptr   <= r_tp;
                        r_state <= S_NHA;
                    end else begin
                        r_pos   <= r_far + PW'(1);
                        r_state <= S_TAG;
                    end
                end
                S_NHA: r_state <= S_NHD;
                S_NHD: begin
                    r_hi    <= {8'd0, r_rdata};
                    r_ptr   <= r_ptr + PW'(1);
                    r_state <= S_NLA;
                end
                S_NLA: r_state <= S_NLD;
                S_NLD: begin
                    r_hi    <= {r_hi[7:0], r_rdata};
                    r_ptr   <= w_j;
                    r_state <= S_NJA;
                end
                S_NJA, S_NJD: begin
                    if ((r_state == S_NJA && !(r_ptr < r_n))
                            || (r_state == S_NJD && r_rdata == 8'd0)) begin
                        if (r_ptr > r_far) r_far <= r_ptr;
                        r_i     <= r_i + 16'd1;
                        r_tp    <= r_tp + PW'(2);
                        r_state <= S_NA;
                    end else if (r_state == S_NJA) begin
                        r_state <= S_NJD;
                    end else begin
                        r_ptr   <= r_ptr + PW'(1);
                        r_state <= S_NJA;
                    end
                end
                S_DA, S_DD: begin
                    if (w_dec_end) begin
                        r_pos   <= r_ptr + PW'(1);
                        r_state <= S_TAG;
                        if (r_val != 16'd0) begin
                            unique case (r_kind)
                                mhtp_pkg::K_SONGS: r_songs <= r_val;
                                mhtp_pkg::K_CUR:   r_cur   <= r_val;
                                default:           r_rate  <= r_val;
                            endcase
                        end
                    end else if (r_state == S_DA) begin
                        r_state <= S_DD;
                    end else begin
                        if (w_digit) r_val <= w_val_nx;
                        r_ptr   <= r_ptr + PW'(1);
                        r_state <= S_DA;
                    end
                end
                S_CLMP: begin
                    if (r_cur > r_songs) r_cur <= r_songs;
                    r_state <= S_TRD;
                end
                S_TRD: begin
                    r_tok   <= w_tin && r_tvalid[w_tidx];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_secs  <= w_secs;
                    r_ticks <= 32'(w_mul_a) * 32'(r_rate);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_period <= i_div_rsp.quotient;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_res_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_div_req   = '{start: (r_state == S_MUL),
                           dividend: mhtp_pkg::CPU_CLOCK_X2 + 24'(r_rate),
                           divisor: {r_rate, 1'b0}};
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = '{status: r_status, header_found: r_found, song_count: r_songs,
                           sel_song: r_cur, play_rate: r_rate, song_seconds: r_secs,
                           total_ticks: r_ticks, frame_period: r_period};
endmodule

// File: hdl/music_header_tag_parser.sv
// Music header tag parser: one byte per cycle while loading. After the last byte it walks
// the tag list, fetching each tag (an unknown tag moves on one byte and fetches again) and
// stepping through string or digit bytes, TIME entries and name-table entries with the bytes
// of each name they point to; then the clamp, TIME read, multiply, divider and output follow.
// Short, packed or untagged files skip the tag walk and the clamp. Input is held off from the last
// byte until the result is queued. Sync active-low reset clears control, not the store.
module music_header_tag_parser #(
    parameter int HEADER_BYTES = 200,
    parameter int TIMED_SONGS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhtp_in_if.sink     i_in,
    mhtp_out_if.source  o_out
);
    logic                w_accept;
    logic                w_idle;
    logic                w_res_valid;
    logic                w_res_ready;
    mhtp_pkg::t_result   w_res;
    mhtp_pkg::t_div_req  w_div_req;
    mhtp_pkg::t_div_rsp  w_div_rsp;
    logic                r_out_valid;
    mhtp_pkg::t_result   r_out;

    assign i_in.ready  = w_idle;
    assign w_accept    = i_in.valid && w_idle;
    assign w_res_ready = !r_out_valid || o_out.ready;

    mhtp_walker #(
        .HEADER_BYTES (HEADER_BYTES),
        .TIMED_SONGS  (TIMED_SONGS)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_file_byte (i_in.file_byte),
        .i_last_byte (i_in.last_byte),
        .o_idle      (w_idle),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    mhtp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
            r_out       <= w_res;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.header_found = r_out.header_found;
    assign o_out.song_count   = r_out.song_count;
    assign o_out.sel_song     = r_out.sel_song;
    assign o_out.play_rate    = r_out.play_rate;
    assign o_out.song_seconds = r_out.song_seconds;
    assign o_out.total_ticks  = r_out.total_ticks;
    assign o_out.frame_period = r_out.frame_period;

    a_err_defaults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != mhtp_pkg::ST_OK) |->
            (!o_out.header_found && o_out.song_count == 16'd1 && o_out.play_rate == 16'd50))
        else $error("error result without default fields");

    a_cur_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.sel_song != 16'd0
                         && o_out.sel_song <= o_out.song_count))
        else $error("current song outside song count");

    a_no_intake_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.busy |-> !i_in.ready)
        else $error("input ready while divider runs");

    a_period_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.frame_period >= 23'd122)
        else $error("frame period out of range");
endmodule
